/* rtl/hhp_pkg.sv */
// ----------------------------------------------------------------------------
// hhp_pkg
// Shared types, codes and constants of the HTTP message head parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hhp_pkg;

	// head length limit and derived counter widths
	localparam int MAX_HEAD_BYTES = 65536;
	localparam int CNT_W          = $clog2(MAX_HEAD_BYTES + 1);
	localparam int OFS_W          = 16;
	localparam int TOK_W          = 3;

	localparam logic [TOK_W-1:0] LINE_TOKENS_RST = 3'd2;

	// characters of interest
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_GLO   = 8'h21;
	localparam logic [7:0] CH_GHI   = 8'h7E;

	// parse phase
	typedef enum logic [3:0] {
		PH_FL_BLANK,
		PH_FL_TOKEN,
		PH_FL_REST,
		PH_FL_CR,
		PH_H_START,
		PH_H_NAME,
		PH_H_VBLANK,
		PH_H_VALUE,
		PH_H_VCR,
		PH_H_VLF,
		PH_H_ENDCR,
		PH_DONE,
		PH_FAIL
	} hhp_phase_t;

	// result event codes
	typedef enum logic [2:0] {
		EV_NONE,
		EV_ELEMENT,
		EV_LINE_END,
		EV_FIELD,
		EV_HEAD_END
	} hhp_event_t;

	// error kinds
	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_CR_NO_LF,
		ERR_LEAD_COLON,
		ERR_NAME_CHAR,
		ERR_TOO_LONG
	} hhp_err_t;

	// one result item
	typedef struct packed {
		hhp_event_t       ev;
		logic             error;
		hhp_err_t         error_kind;
		logic [TOK_W-1:0] element_index;
		logic [OFS_W-1:0] element_offset;
		logic [OFS_W-1:0] element_size;
		logic [OFS_W-1:0] name_offset;
		logic [OFS_W-1:0] name_size;
		logic [OFS_W-1:0] value_pos;
		logic [OFS_W-1:0] value_size;
	} hhp_res_t;

endpackage

`default_nettype wire

/* rtl/hhp_core.sv */
// ----------------------------------------------------------------------------
// hhp_core
// Per-byte parse state machine: holds the parse state and works out the
// result of each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hhp_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_fire,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        message_start,
	input  wire logic [hhp_pkg::TOK_W-1:0]   line_tokens,
	output hhp_pkg::hhp_res_t                res
);
	import hhp_pkg::*;

	hhp_phase_t       phase_q, phase_d;
	logic [CNT_W-1:0] byte_count_q, byte_count_d;
	logic [OFS_W-1:0] element_start_q, element_start_d;
	logic [TOK_W-1:0] element_number_q, element_number_d;
	logic [OFS_W-1:0] field_start_q, field_start_d;
	logic [OFS_W-1:0] field_name_len_q, field_name_len_d;
	logic [OFS_W-1:0] value_start_q, value_start_d;
	logic [OFS_W-1:0] value_end_q, value_end_d;

	// effective state after an optional message restart
	hhp_phase_t       ph;
	logic [CNT_W-1:0] bc;
	logic [OFS_W-1:0] pos;
	logic             b_blank, b_graph, b_wspace;
	logic             do_line_start, do_value;

	// character classes
	always_comb begin
		b_blank  = (data_byte == CH_SP) || (data_byte == CH_TAB);
		b_graph  = (data_byte >= CH_GLO) && (data_byte <= CH_GHI);
		b_wspace = (data_byte == CH_SP) || (data_byte == CH_TAB) || (data_byte == CH_LF)
			|| (data_byte == CH_VT) || (data_byte == CH_FF) || (data_byte == CH_CR);
	end

	// next state and result
	always_comb begin
		ph  = message_start ? PH_FL_BLANK : phase_q;
		bc  = message_start ? '0 : byte_count_q;
		pos = OFS_W'(bc);

		phase_d          = ph;
		byte_count_d     = bc;
		element_start_d  = message_start ? '0 : element_start_q;
		element_number_d = message_start ? '0 : element_number_q;
		field_start_d    = message_start ? '0 : field_start_q;
		field_name_len_d = message_start ? '0 : field_name_len_q;
		value_start_d    = message_start ? '0 : value_start_q;
		value_end_d      = message_start ? '0 : value_end_q;

		res           = '0;
		do_line_start = 1'b0;
		do_value      = 1'b0;

		if (ph == PH_DONE || ph == PH_FAIL) begin
			// finished or failed head: quiet until restart
		end else if (bc >= CNT_W'(MAX_HEAD_BYTES)) begin
			phase_d        = PH_FAIL;
			res.error      = 1'b1;
			res.error_kind = ERR_TOO_LONG;
		end else begin
			byte_count_d = CNT_W'(bc + 1'b1);
			case (ph)
				PH_FL_BLANK: begin
					if (data_byte == CH_CR) begin
						phase_d = PH_FL_CR;
					end else if (!b_blank) begin
						element_start_d = pos;
						phase_d = (element_number_d < line_tokens) ? PH_FL_TOKEN : PH_FL_REST;
					end
				end
				PH_FL_TOKEN: begin
					if (b_blank || data_byte == CH_CR) begin
						res.ev             = EV_ELEMENT;
						res.element_index  = element_number_d;
						res.element_offset = element_start_d;
						res.element_size   = pos - element_start_d;
						if (element_number_d != {TOK_W{1'b1}})
							element_number_d = element_number_d + 1'b1;
						phase_d = (data_byte == CH_CR) ? PH_FL_CR : PH_FL_BLANK;
					end
				end
				PH_FL_REST: begin
					if (data_byte == CH_CR) begin
						res.ev             = EV_ELEMENT;
						res.element_index  = element_number_d;
						res.element_offset = element_start_d;
						res.element_size   = pos - element_start_d;
						phase_d            = PH_FL_CR;
					end
				end
				PH_FL_CR: begin
					if (data_byte == CH_LF) begin
						res.ev  = EV_LINE_END;
						phase_d = PH_H_START;
					end else begin
						phase_d        = PH_FAIL;
						res.error      = 1'b1;
						res.error_kind = ERR_CR_NO_LF;
					end
				end
				PH_H_START: begin
					do_line_start = 1'b1;
				end
				PH_H_NAME: begin
					if (data_byte == CH_COLON) begin
						field_name_len_d = pos - field_start_d;
						phase_d          = PH_H_VBLANK;
					end else if (!b_graph) begin
						phase_d        = PH_FAIL;
						res.error      = 1'b1;
						res.error_kind = ERR_NAME_CHAR;
					end
				end
				PH_H_VBLANK: begin
					if (!b_blank) begin
						value_start_d = pos;
						value_end_d   = pos;
						do_value      = 1'b1;
					end
				end
				PH_H_VALUE: begin
					do_value = 1'b1;
				end
				PH_H_VCR: begin
					if (data_byte == CH_LF) begin
						phase_d = PH_H_VLF;
					end else begin
						phase_d        = PH_FAIL;
						res.error      = 1'b1;
						res.error_kind = ERR_CR_NO_LF;
					end
				end
				PH_H_VLF: begin
					if (b_blank) begin
						phase_d = PH_H_VALUE;
					end else begin
						res.ev          = EV_FIELD;
						res.name_offset = field_start_d;
						res.name_size   = field_name_len_d;
						res.value_pos   = value_start_d;
						res.value_size  = value_end_d - value_start_d;
						do_line_start   = 1'b1;
					end
				end
				PH_H_ENDCR: begin
					if (data_byte == CH_LF) begin
						res.ev  = EV_HEAD_END;
						phase_d = PH_DONE;
					end else begin
						phase_d        = PH_FAIL;
						res.error      = 1'b1;
						res.error_kind = ERR_NAME_CHAR;
					end
				end
				default: begin
					phase_d = ph;
				end
			endcase

			// first byte of a header line
			if (do_line_start) begin
				if (data_byte == CH_CR) begin
					phase_d = PH_H_ENDCR;
				end else if (data_byte == CH_COLON) begin
					phase_d        = PH_FAIL;
					res.error      = 1'b1;
					res.error_kind = ERR_LEAD_COLON;
				end else if (!b_graph) begin
					phase_d        = PH_FAIL;
					res.error      = 1'b1;
					res.error_kind = ERR_NAME_CHAR;
				end else begin
					field_start_d = pos;
					phase_d       = PH_H_NAME;
				end
			end

			// byte inside a header value
			if (do_value) begin
				if (data_byte == CH_CR) begin
					phase_d = PH_H_VCR;
				end else begin
					if (!b_wspace)
						value_end_d = pos + 1'b1;
					phase_d = PH_H_VALUE;
				end
			end
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_FL_BLANK;
			byte_count_q     <= '0;
			element_start_q  <= '0;
			element_number_q <= '0;
			field_start_q    <= '0;
			field_name_len_q <= '0;
			value_start_q    <= '0;
			value_end_q      <= '0;
		end else if (in_fire) begin
			phase_q          <= phase_d;
			byte_count_q     <= byte_count_d;
			element_start_q  <= element_start_d;
			element_number_q <= element_number_d;
			field_start_q    <= field_start_d;
			field_name_len_q <= field_name_len_d;
			value_start_q    <= value_start_d;
			value_end_q      <= value_end_d;
		end
	end

	// an error always lands the parser in the failed phase
	a_error_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.error |=> phase_q == PH_FAIL)
		else $error("error did not leave the parser failed");

	// end of headers always lands the parser in the done phase
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.ev == EV_HEAD_END |=> phase_q == PH_DONE)
		else $error("end of headers did not finish the parse");

	// an error never comes without its kind
	a_error_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.error |-> res.error_kind != ERR_NONE)
		else $error("error raised without a kind");

	// the byte counter never passes the head limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_W'(MAX_HEAD_BYTES))
		else $error("byte counter beyond head limit");

endmodule

`default_nettype wire

/* rtl/hhp_out_reg.sv */
// ----------------------------------------------------------------------------
// hhp_out_reg
// Result register between the parser and the result channel; holds a
// stalled result and lets the next byte in as soon as the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module hhp_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_fire,
	input  wire hhp_pkg::hhp_res_t  res_d,
	input  wire logic               out_stall,
	output logic                    take,
	output logic                    out_valid,
	output hhp_pkg::hhp_res_t       res_q
);
	import hhp_pkg::*;

	logic valid_q;

	// slot can load when empty or being emptied this cycle
	assign take      = !(valid_q && out_stall);
	assign out_valid = valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= in_fire;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	// a transfer in always leaves a result waiting
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_q)
		else $error("accepted byte gave no result");

	// no byte is taken into a full, stalled slot
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |-> !in_fire)
		else $error("result slot overrun");

	// a drained slot with nothing new goes empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_stall && !in_fire |=> !valid_q)
		else $error("result repeated after transfer");

endmodule

`default_nettype wire

/* rtl/http_head_parser_unit.sv */
// ----------------------------------------------------------------------------
// http_head_parser_unit
// Streaming parser for the head of an HTTP/1.1 message, one byte per item.
//
// Input channel: in_valid / in_stall with data_byte and message_start; a
// byte is transferred when in_valid is high and in_stall is low. Set
// message_start on the first byte of each message to clear parse state.
// Result channel: out_valid / out_stall with one result per input byte
// (event, error and the offsets and lengths of elements and fields).
// Config channel: cfg_valid / cfg_ready, cfg_data = line_tokens; the user must
// write it only while idle, unenforced by the block. cfg_ready is always high.
// A result is registered and appears in the cycle after its byte transfers.
// Throughput: one byte per cycle while the result channel does not stall, set
// by the per-byte state update in the parse core feeding one result register.
// Reset: parse state clears, line_tokens returns to 2, no result is held.
// Stall: a stalled result holds in the result register and in_stall rises
// so no further byte is taken until the result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module http_head_parser_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// byte input
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        message_start,
	// result output
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [2:0]                       event_res,
	output logic                             error,
	output logic [2:0]                       error_kind,
	output logic [hhp_pkg::TOK_W-1:0]        element_index,
	output logic [hhp_pkg::OFS_W-1:0]        element_offset,
	output logic [hhp_pkg::OFS_W-1:0]        element_size,
	output logic [hhp_pkg::OFS_W-1:0]        name_offset,
	output logic [hhp_pkg::OFS_W-1:0]        name_size,
	output logic [hhp_pkg::OFS_W-1:0]        value_pos,
	output logic [hhp_pkg::OFS_W-1:0]        value_size,
	// configuration
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [hhp_pkg::TOK_W-1:0]   cfg_data
);
	import hhp_pkg::*;

	logic             take;
	logic             in_fire;
	logic [TOK_W-1:0] line_tokens_q;
	hhp_res_t         res_d;
	hhp_res_t         res_q;

	// input handshake
	assign in_stall  = !take;
	assign in_fire   = in_valid && take;
	assign cfg_ready = 1'b1;

	// line token count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_tokens_q <= LINE_TOKENS_RST;
		end else if (cfg_valid && cfg_ready) begin
			line_tokens_q <= cfg_data;
		end
	end

	// parse core
	hhp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.data_byte     (data_byte),
		.message_start (message_start),
		.line_tokens   (line_tokens_q),
		.res           (res_d)
	);

	// result register
	hhp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.res_d     (res_d),
		.out_stall (out_stall),
		.take      (take),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	// result fields
	assign event_res      = res_q.ev;
	assign error          = res_q.error;
	assign error_kind     = res_q.error_kind;
	assign element_index  = res_q.element_index;
	assign element_offset = res_q.element_offset;
	assign element_size   = res_q.element_size;
	assign name_offset    = res_q.name_offset;
	assign name_size      = res_q.name_size;
	assign value_pos      = res_q.value_pos;
	assign value_size     = res_q.value_size;

	// element fields are quiet unless an element is reported
	a_elem_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_ELEMENT |->
			element_offset == '0 && element_size == '0 && element_index == '0)
		else $error("element fields set without element event");

	// header fields are quiet unless a field is reported
	a_field_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_FIELD |->
			name_offset == '0 && name_size == '0 && value_pos == '0
			&& value_size == '0)
		else $error("header fields set without field event");

	// a result only follows a transferred byte
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid) && !$past(in_stall))
		else $error("result without an input byte");

endmodule

`default_nettype wire
